// ===== hdl/sbag_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types.
package sbag_pkg;

    localparam int SRC_IMG_WIDTH  = 1024;
    localparam int SRC_IMG_HEIGHT = 1024;
    localparam int DST_IMG_WIDTH  = 1024;
    localparam int DST_IMG_HEIGHT = 1024;

    localparam int CRD_W     = 12;
    localparam int QUO_W     = 2 * CRD_W;
    localparam int SX_W      = QUO_W + 2;
    localparam int DX_W      = CRD_W + 2;
    localparam int ADDR_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SRC_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd7;

    typedef struct packed {
        logic accept;
        logic drop;
        logic mul;
        logic div_start;
        logic eval;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic empty;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/sbag_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module sbag_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sbag_pkg::QUO_W-1:0] dividend,
    input  logic [sbag_pkg::CRD_W-1:0] divisor,
    output logic [sbag_pkg::QUO_W-1:0] quotient,
    output logic                      busy
);
    import sbag_pkg::*;

    logic [QUO_W-1:0]     qn_reg;
    logic [QUO_W-1:0]     qn_next;
    logic [CRD_W-1:0]     rem_reg;
    logic [CRD_W-1:0]     rem_next;
    logic [CRD_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [CRD_W:0]       rem_sh;
    logic [CRD_W:0]       rem_sub;
    logic                 ge;

    always_comb
    begin
        rem_sh   = {rem_reg, qn_reg[QUO_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        rem_next = ge ? rem_sub[CRD_W-1:0] : rem_sh[CRD_W-1:0];
        qn_next  = {qn_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qn_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            qn_reg  <= qn_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = qn_reg;
    assign busy     = busy_reg;

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero step count");

endmodule

// ===== hdl/sbag_datapath.sv =====
// Datapath: register file, walk counters, scaling dividers, address and output stages.
module sbag_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [sbag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbag_pkg::CRD_W-1:0]     cfg_data,
    input  logic                          restart,
    input  sbag_pkg::cmd_t                cmd,
    output sbag_pkg::sts_t                sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [sbag_pkg::ADDR_W-1:0]    src_word_addr,
    output logic                          src_inside,
    output logic [sbag_pkg::ADDR_W-1:0]    dst_word_addr,
    output logic                          dst_write,
    output logic                          last_access
);
    import sbag_pkg::*;

    logic [CRD_W-1:0] src_left_reg;
    logic [CRD_W-1:0] src_top_reg;
    logic [CRD_W-1:0] src_width_reg;
    logic [CRD_W-1:0] src_height_reg;
    logic [CRD_W-1:0] dst_left_reg;
    logic [CRD_W-1:0] dst_top_reg;
    logic [CRD_W-1:0] dst_width_reg;
    logic [CRD_W-1:0] dst_height_reg;

    logic [CRD_W-1:0] col_reg;
    logic [CRD_W-1:0] row_reg;
    logic             active_reg;
    logic [CRD_W-1:0] col_next;
    logic [CRD_W-1:0] row_next;
    logic             active_next;

    logic [QUO_W-1:0] xprod_reg;
    logic [QUO_W-1:0] yprod_reg;
    logic [QUO_W-1:0] xquo;
    logic [QUO_W-1:0] yquo;
    logic             xbusy;
    logic             ybusy;

    logic [SX_W-1:0]  sx;
    logic [SX_W-1:0]  sy;
    logic [DX_W-1:0]  dx;
    logic [DX_W-1:0]  dy;
    logic             sin;
    logic             dwr;
    logic [CRD_W:0]   row_inc;
    logic [CRD_W:0]   col_inc;
    logic             last;

    logic [CRD_W-1:0] sx_reg;
    logic [CRD_W-1:0] sy_reg;
    logic [CRD_W-1:0] dx_reg;
    logic [CRD_W-1:0] dy_reg;
    logic             sin_reg;
    logic             dwr_reg;
    logic             last_reg;

    logic [QUO_W-1:0] src_prod;
    logic [QUO_W-1:0] dst_prod;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] src_addr_reg;
    logic              src_inside_reg;
    logic [ADDR_W-1:0] dst_addr_reg;
    logic              dst_write_reg;
    logic              last_access_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_left_reg   <= '0;
            src_top_reg    <= '0;
            src_width_reg  <= '0;
            src_height_reg <= '0;
            dst_left_reg   <= '0;
            dst_top_reg    <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SRC_LEFT:   src_left_reg   <= cfg_data;
                REG_SRC_TOP:    src_top_reg    <= cfg_data;
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_LEFT:   dst_left_reg   <= cfg_data;
                REG_DST_TOP:    dst_top_reg    <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default:        src_left_reg   <= src_left_reg;
            endcase
        end
    end

    // source and destination points of the current pixel
    always_comb
    begin
        sx  = {{(SX_W-CRD_W){src_left_reg[CRD_W-1]}}, src_left_reg} + {2'b00, xquo};
        sy  = {{(SX_W-CRD_W){src_top_reg[CRD_W-1]}}, src_top_reg} + {2'b00, yquo};
        dx  = {{(DX_W-CRD_W){dst_left_reg[CRD_W-1]}}, dst_left_reg} + {2'b00, col_reg};
        dy  = {{(DX_W-CRD_W){dst_top_reg[CRD_W-1]}}, dst_top_reg} + {2'b00, row_reg};
        sin = !sx[SX_W-1] && (sx < SX_W'(SRC_IMG_WIDTH))
            && !sy[SX_W-1] && (sy < SX_W'(SRC_IMG_HEIGHT));
        dwr = !dx[DX_W-1] && (dx < DX_W'(DST_IMG_WIDTH))
            && !dy[DX_W-1] && (dy < DX_W'(DST_IMG_HEIGHT));
    end

    // restart or clear the walk, else advance down the column, wrap to the next column, end after the last one
    always_comb
    begin
        row_inc = {1'b0, row_reg} + 1'b1;
        col_inc = {1'b0, col_reg};
        if (row_inc >= {1'b0, dst_height_reg})
        begin
            row_inc = '0;
            col_inc = {1'b0, col_reg} + 1'b1;
        end
        last = col_inc >= {1'b0, dst_width_reg};

        col_next    = col_reg;
        row_next    = row_reg;
        active_next = active_reg;
        if (cmd.accept && restart)
        begin
            col_next    = '0;
            row_next    = '0;
            active_next = 1'b1;
        end
        else if (cmd.drop)
        begin
            col_next    = '0;
            row_next    = '0;
            active_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            if (last)
            begin
                col_next    = '0;
                row_next    = '0;
                active_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[CRD_W-1:0];
                row_next = row_inc[CRD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            xprod_reg <= QUO_W'(col_reg) * QUO_W'(src_width_reg);
            yprod_reg <= QUO_W'(row_reg) * QUO_W'(src_height_reg);
        end
    end

    sbag_div u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (xprod_reg),
        .divisor  (dst_width_reg),
        .quotient (xquo),
        .busy     (xbusy)
    );

    sbag_div u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (yprod_reg),
        .divisor  (dst_height_reg),
        .quotient (yquo),
        .busy     (ybusy)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            sx_reg   <= sx[CRD_W-1:0];
            sy_reg   <= sy[CRD_W-1:0];
            dx_reg   <= dx[CRD_W-1:0];
            dy_reg   <= dy[CRD_W-1:0];
            sin_reg  <= sin;
            dwr_reg  <= dwr;
            last_reg <= last;
        end
    end

    always_comb
    begin
        src_prod = QUO_W'(sy_reg) * QUO_W'(SRC_IMG_WIDTH);
        dst_prod = QUO_W'(dy_reg) * QUO_W'(DST_IMG_WIDTH);
        src_addr = sin_reg ? src_prod[ADDR_W-1:0] + ADDR_W'(sx_reg) : '0;
        dst_addr = dwr_reg ? dst_prod[ADDR_W-1:0] + ADDR_W'(dx_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_addr_reg    <= src_addr;
            src_inside_reg  <= sin_reg;
            dst_addr_reg    <= dst_addr;
            dst_write_reg   <= dwr_reg;
            last_access_reg <= last_reg;
        end
    end

    always_comb
    begin
        sts.active   = active_reg;
        sts.empty    = (dst_width_reg == '0) || (dst_height_reg == '0);
        sts.div_busy = xbusy || ybusy;
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign src_word_addr = src_addr_reg;
    assign src_inside    = src_inside_reg;
    assign dst_word_addr = dst_addr_reg;
    assign dst_write     = dst_write_reg;
    assign last_access   = last_access_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before taken");

    a_eval_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (!xbusy && !ybusy && active_reg))
        else $error("pixel evaluated with dividers busy or walk idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && last) |=> (!active_reg && col_reg == '0 && row_reg == '0))
        else $error("walk not idle after final pixel");

endmodule

// ===== hdl/sbag_ctrl.sv =====
// Controller: sequences accept, check, divide, evaluate and output load per word.
module sbag_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sbag_pkg::sts_t sts,
    output sbag_pkg::cmd_t cmd
);
    import sbag_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_EVAL,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.active)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.empty)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== hdl/scaled_blit_address_generator_unit.sv =====
// Top level of the nearest-neighbor scaled blit address generator.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------------------
//  in       | in_valid, in_ready, restart               | step word: restart or advance
//  out      | out_valid, out_ready, src_word_addr,      | access word for one pixel
//           | src_inside, dst_word_addr, dst_write,     |
//           | last_access                               |
//  cfg      | cfg_write, cfg_index, cfg_data            | rectangle registers, no wait
//
//  A pixel word passes from accept through check and products, divider load,
//  divider run (quotient steps until both dividers are done), evaluate and
//  addresses. A word that issues nothing returns to idle after the check.
//  Reset clears the registers, the walk and the output stage; no clearing pass follows.
//  A stalled output word holds; the next step word is accepted meanwhile and waits
//  before the address stage until the output register frees.
module scaled_blit_address_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sbag_pkg::ADDR_W-1:0]    src_word_addr,
    output logic                          src_inside,
    output logic [sbag_pkg::ADDR_W-1:0]    dst_word_addr,
    output logic                          dst_write,
    output logic                          last_access,
    input  logic                          cfg_write,
    input  logic [sbag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbag_pkg::CRD_W-1:0]     cfg_data
);
    import sbag_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sbag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbag_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .restart       (restart),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .src_word_addr (src_word_addr),
        .src_inside    (src_inside),
        .dst_word_addr (dst_word_addr),
        .dst_write     (dst_write),
        .last_access   (last_access)
    );

endmodule
